### hw/rtl/nacc_pkg.sv
package nacc_pkg;

  // Instruction codes carried by the action field
  typedef enum logic [4:0] {
    ACT_ADD       = 5'd0,
    ACT_SUB       = 5'd1,
    ACT_LD        = 5'd2,
    ACT_XCH       = 5'd3,
    ACT_INC       = 5'd4,
    ACT_LDM       = 5'd5,
    ACT_ADM       = 5'd6,
    ACT_SBM       = 5'd7,
    ACT_READ_IN   = 5'd8,
    ACT_CLB       = 5'd9,
    ACT_CLC       = 5'd10,
    ACT_IAC       = 5'd11,
    ACT_CMC       = 5'd12,
    ACT_CMA       = 5'd13,
    ACT_RAL       = 5'd14,
    ACT_RAR       = 5'd15,
    ACT_TCC       = 5'd16,
    ACT_DAC       = 5'd17,
    ACT_TCS       = 5'd18,
    ACT_STC       = 5'd19,
    ACT_DAA       = 5'd20,
    ACT_KBP       = 5'd21,
    ACT_OR        = 5'd22,
    ACT_AND       = 5'd23,
    ACT_LOAD_PAIR = 5'd24,
    ACT_READ_PAIR = 5'd25
  } action_t;

  typedef logic [3:0] nibble_t;
  typedef logic [7:0] byte_t;
  typedef logic [2:0] pair_idx_t;

  // Decimal adjust constants
  localparam nibble_t DAA_LIMIT = 4'd9;
  localparam nibble_t DAA_ADD   = 4'd6;
  // Values produced by transfer carry subtract
  localparam nibble_t TCS_SET   = 4'd10;
  localparam nibble_t TCS_CLR   = 4'd9;
  // Keyboard process output for an invalid code
  localparam nibble_t KBP_ERR   = 4'b1111;

  // Register file write port
  typedef struct packed {
    logic      we;
    pair_idx_t idx;
    byte_t     data;
  } rf_wr_t;

  // Next state computed for one instruction
  typedef struct packed {
    nibble_t acc;
    logic    carry;
    logic    pair_we;
    byte_t   pair_data;
  } alu_res_t;

endpackage

### hw/rtl/nacc_regfile.sv
module nacc_regfile
  import nacc_pkg::*;
#(
  parameter int REGISTER_COUNT = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pair_idx_t rd_idx,
  output byte_t     rd_data,
  input  rf_wr_t    wr
);

  localparam int PAIRS = (REGISTER_COUNT + 1) / 2;
  localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

  byte_t pairs_r [PAIRS];

  logic  rd_ok;
  logic  hi_ok;
  logic  lo_ok;
  byte_t rd_raw;

  // Read one pair; nibbles beyond the register count read as zero
  always_comb begin
    rd_ok  = int'(rd_idx) < PAIRS;
    hi_ok  = (2 * int'(rd_idx)) < REGISTER_COUNT;
    lo_ok  = (2 * int'(rd_idx) + 1) < REGISTER_COUNT;
    rd_raw = rd_ok ? pairs_r[rd_idx[PW-1:0]] : '0;
    rd_data = {(hi_ok ? rd_raw[7:4] : 4'd0), (lo_ok ? rd_raw[3:0] : 4'd0)};
  end

  // Hold the pairs; drop writes to pairs that do not exist
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAIRS; i++) pairs_r[i] <= '0;
    end else if (wr.we && (int'(wr.idx) < PAIRS)) begin
      pairs_r[wr.idx[PW-1:0]] <= wr.data;
    end
  end

endmodule

### hw/rtl/nacc_alu.sv
module nacc_alu
  import nacc_pkg::*;
(
  input  logic [4:0] action,
  input  logic       odd_sel,
  input  nibble_t    data_nibble,
  input  byte_t      data_byte,
  input  nibble_t    acc,
  input  logic       carry,
  input  byte_t      pair_rd,
  output alu_res_t   res
);

  nibble_t     rv;
  logic [4:0]  sum;
  nibble_t     add_op;
  logic        add_cin;
  logic [4:0]  daa_sum;

  // Pick the selected nibble of the pair
  assign rv = odd_sel ? pair_rd[3:0] : pair_rd[7:4];

  // Shared adder operand selection
  always_comb begin
    add_op  = rv;
    add_cin = carry;
    unique case (action)
      ACT_SUB: begin
        add_op  = ~rv;
        add_cin = ~carry;
      end
      ACT_ADM: begin
        add_op  = data_nibble;
        add_cin = carry;
      end
      ACT_SBM: begin
        add_op  = ~data_nibble;
        add_cin = ~carry;
      end
      ACT_IAC: begin
        add_op  = 4'd1;
        add_cin = 1'b0;
      end
      default: begin
        add_op  = rv;
        add_cin = carry;
      end
    endcase
  end

  assign sum     = {1'b0, acc} + {1'b0, add_op} + {4'd0, add_cin};
  assign daa_sum = {1'b0, acc} + {1'b0, DAA_ADD};

  // Decode and compute the next accumulator, carry and pair
  always_comb begin
    res.acc       = acc;
    res.carry     = carry;
    res.pair_we   = 1'b0;
    res.pair_data = pair_rd;
    unique case (action)
      ACT_ADD, ACT_SUB, ACT_ADM, ACT_SBM, ACT_IAC: begin
        res.acc   = sum[3:0];
        res.carry = sum[4];
      end
      ACT_LD: res.acc = rv;
      ACT_XCH: begin
        res.acc     = rv;
        res.pair_we = 1'b1;
        res.pair_data = odd_sel ? {pair_rd[7:4], acc} : {acc, pair_rd[3:0]};
      end
      ACT_INC: begin
        res.pair_we = 1'b1;
        res.pair_data = odd_sel ? {pair_rd[7:4], rv + 4'd1}
                                : {rv + 4'd1, pair_rd[3:0]};
      end
      ACT_LDM, ACT_READ_IN: res.acc = data_nibble;
      ACT_CLB: begin
        res.acc   = '0;
        res.carry = 1'b0;
      end
      ACT_CLC: res.carry = 1'b0;
      ACT_CMC: res.carry = ~carry;
      ACT_CMA: res.acc = ~acc;
      ACT_RAL: begin
        res.acc   = {acc[2:0], carry};
        res.carry = acc[3];
      end
      ACT_RAR: begin
        res.acc   = {carry, acc[3:1]};
        res.carry = acc[0];
      end
      ACT_TCC: begin
        res.acc   = {3'd0, carry};
        res.carry = 1'b0;
      end
      ACT_DAC: begin
        res.acc   = acc - 4'd1;
        res.carry = acc != 4'd0;
      end
      ACT_TCS: begin
        res.acc   = carry ? TCS_SET : TCS_CLR;
        res.carry = 1'b0;
      end
      ACT_STC: res.carry = 1'b1;
      ACT_DAA: begin
        if (acc > DAA_LIMIT || carry) begin
          res.acc = daa_sum[3:0];
          if (daa_sum[4]) res.carry = 1'b1;
        end
      end
      ACT_KBP: begin
        unique case (acc)
          4'd0, 4'd1, 4'd2: res.acc = acc;
          4'd4:             res.acc = 4'd3;
          4'd8:             res.acc = 4'd4;
          default:          res.acc = KBP_ERR;
        endcase
      end
      ACT_OR:  res.acc = acc | rv;
      ACT_AND: res.acc = acc & rv;
      ACT_LOAD_PAIR: begin
        res.pair_we   = 1'b1;
        res.pair_data = data_byte;
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/nibble_accumulator_alu_regfile.sv
// A result beat passes through the input register and then the result register.
// Throughput: one instruction per cycle when not stalled; the register file, accumulator and
// carry are updated in the cycle that executes an instruction, so the next one sees them.
// Reset (synchronous, rst_n low): accumulator, carry and all index registers clear to zero,
// both pipeline stages empty.
module nibble_accumulator_alu_regfile
  import nacc_pkg::*;
#(
  parameter int REGISTER_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [4:0] in_action,
  input  logic [3:0] in_reg_index,
  input  logic [3:0] in_data_nibble,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_acc_value,
  output logic       out_carry_flag,
  output logic [3:0] out_reg_value,
  output logic [7:0] out_pair_value
);

  logic       in_valid_r;
  logic [4:0] action_r;
  logic [3:0] reg_index_r;
  nibble_t    data_nibble_r;
  byte_t      data_byte_r;

  nibble_t    acc_r;
  logic       carry_r;

  logic       out_valid_r;
  nibble_t    acc_value_r;
  logic       carry_flag_r;
  nibble_t    reg_value_r;
  byte_t      pair_value_r;

  logic       advance;
  logic       exec;
  byte_t      pair_rd;
  byte_t      pair_new;
  byte_t      pair_after;
  alu_res_t   res;
  rf_wr_t     rf_wr;

  // Result stage moves when empty or taken
  assign advance  = !out_valid_r || !out_stall;
  assign exec     = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      action_r      <= in_action;
      reg_index_r   <= in_reg_index;
      data_nibble_r <= in_data_nibble;
      data_byte_r   <= in_data_byte;
    end
  end

  nacc_regfile #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_regfile (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (reg_index_r[3:1]),
    .rd_data(pair_rd),
    .wr     (rf_wr)
  );

  nacc_alu u_alu (
    .action     (action_r),
    .odd_sel    (reg_index_r[0]),
    .data_nibble(data_nibble_r),
    .data_byte  (data_byte_r),
    .acc        (acc_r),
    .carry      (carry_r),
    .pair_rd    (pair_rd),
    .res        (res)
  );

  // Write back the pair on execute
  assign rf_wr.we   = exec && res.pair_we;
  assign rf_wr.idx  = reg_index_r[3:1];
  assign rf_wr.data = res.pair_data;

  // Pair as seen after the step; nibbles that do not exist stay zero
  assign pair_new = res.pair_we ? res.pair_data : pair_rd;
  always_comb begin
    pair_after = pair_new;
    if ((2 * int'(reg_index_r[3:1])) >= REGISTER_COUNT) pair_after[7:4] = 4'd0;
    if ((2 * int'(reg_index_r[3:1]) + 1) >= REGISTER_COUNT) pair_after[3:0] = 4'd0;
  end

  // Accumulator, carry and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      carry_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (exec) begin
        acc_r   <= res.acc;
        carry_r <= res.carry;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
    if (exec) begin
      acc_value_r  <= res.acc;
      carry_flag_r <= res.carry;
      reg_value_r  <= reg_index_r[0] ? pair_after[3:0] : pair_after[7:4];
      pair_value_r <= pair_after;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_acc_value  = acc_value_r;
  assign out_carry_flag = carry_flag_r;
  assign out_reg_value  = reg_value_r;
  assign out_pair_value = pair_value_r;

endmodule
